// ===== rtl/nap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nap_pkg: shared types and constants
// Byte codes, register indexes, status codes and parser phases for the
// notification attribute response parser.
// ----------------------------------------------------------------------------
package nap_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int BYTE_CNT_W   = $clog2(BUFFER_BYTES + 1);

  typedef logic [BYTE_CNT_W-1:0] byte_cnt_t;

  // header is the command byte plus four uid bytes
  localparam int UID_END_COUNT = 5;

  localparam logic [3:0] WANT_TEXT = 4'he;
  localparam logic [3:0] WANT_APP  = 4'h1;

  localparam logic [15:0] APP_LIMIT = 16'd255;

  localparam logic [1:0] ATTR_APP     = 2'd0;
  localparam logic [1:0] ATTR_MESSAGE = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_REQUEST_UID   = 2'd0;
  localparam cfg_idx_t CFG_EXPECT_TEXT   = 2'd1;
  localparam cfg_idx_t CFG_TITLE_LIMIT   = 2'd2;
  localparam cfg_idx_t CFG_MESSAGE_LIMIT = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_MORE = 2'd0;
  localparam status_t ST_DONE = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  localparam logic CMD_FEED    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [5:0] {
    PH_CMD = 6'b000001,
    PH_UID = 6'b000010,
    PH_ID  = 6'b000100,
    PH_LLO = 6'b001000,
    PH_LHI = 6'b010000,
    PH_PAY = 6'b100000
  } phase_t;

endpackage

// ===== rtl/notification_attribute_response_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notification_attribute_response_parser
// Byte-wise checker for a notification attribute response. Validates the
// command byte, the echoed uid, each attribute record header and the buffer
// budget, and passes payload bytes out tagged with their attribute id.
// ----------------------------------------------------------------------------
// Takes one beat per clock: each accepted byte (or restart) is decoded
// against the parse state and yields exactly one result beat, visible in
// the output register on the following cycle. Input is stalled
// only while a result sits in the output register and the consumer stalls
// it; with the output side free the block sustains one byte per cycle.
// Errors are sticky until a restart beat. Configuration registers are read
// live and may be written between responses.
module notification_attribute_response_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  nap_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_payload_valid,
  output logic [1:0]        out_payload_attr,
  output logic [7:0]        out_payload_byte,
  output logic              out_payload_last
);

  import nap_pkg::*;

  // configuration
  logic [31:0] request_uid_r;
  logic        expect_text_r;
  logic [15:0] title_limit_r;
  logic [15:0] message_limit_r;

  // parse state
  phase_t      phase_r,         phase_nxt;
  byte_cnt_t   bytes_used_r,    bytes_used_nxt;
  logic [31:0] uid_shift_r,     uid_shift_nxt;
  logic [3:0]  seen_mask_r,     seen_mask_nxt;
  logic [1:0]  current_attr_r,  current_attr_nxt;
  logic [15:0] remaining_len_r, remaining_len_nxt;
  logic        done_r,          done_nxt;
  logic        failed_r,        failed_nxt;
  logic [7:0]  held_id_r,       held_id_nxt;

  // result register
  logic        out_valid_r;
  status_t     status_r,  status_nxt;
  logic        pv_r,      pv_nxt;
  logic [1:0]  pa_r,      pa_nxt;
  logic [7:0]  pb_r,      pb_nxt;
  logic        pl_r,      pl_nxt;

  logic        accept;
  logic        bad;
  logic [3:0]  wanted;
  logic [3:0]  id_bit;
  logic [3:0]  fin_mask;
  logic [1:0]  fin_attr;
  logic        fin;
  logic [15:0] len_full;
  logic [15:0] limit;
  logic [15:0] len_dec;
  logic [31:0] uid_shifted;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign wanted   = expect_text_r ? WANT_TEXT : WANT_APP;

  assign id_bit      = 4'b0001 << held_id_r[1:0];
  assign len_full    = {in_data_byte, remaining_len_r[7:0]};
  assign limit       = (held_id_r[1:0] == ATTR_APP)     ? APP_LIMIT :
                       (held_id_r[1:0] == ATTR_MESSAGE) ? message_limit_r : title_limit_r;
  assign len_dec     = remaining_len_r - 16'd1;
  assign uid_shifted = {in_data_byte, uid_shift_r[31:8]};

  always_comb begin
    phase_nxt         = phase_r;
    bytes_used_nxt    = bytes_used_r;
    uid_shift_nxt     = uid_shift_r;
    seen_mask_nxt     = seen_mask_r;
    current_attr_nxt  = current_attr_r;
    remaining_len_nxt = remaining_len_r;
    done_nxt          = done_r;
    failed_nxt        = failed_r;
    held_id_nxt       = held_id_r;
    status_nxt        = ST_MORE;
    pv_nxt            = 1'b0;
    pa_nxt            = 2'd0;
    pb_nxt            = 8'd0;
    pl_nxt            = 1'b0;
    bad               = 1'b0;
    fin               = 1'b0;
    fin_attr          = current_attr_r;

    if (in_command == CMD_RESTART) begin
      phase_nxt         = PH_CMD;
      bytes_used_nxt    = '0;
      uid_shift_nxt     = '0;
      seen_mask_nxt     = '0;
      current_attr_nxt  = '0;
      remaining_len_nxt = '0;
      done_nxt          = 1'b0;
      failed_nxt        = 1'b0;
      held_id_nxt       = '0;
    end else if (failed_r || done_r || bytes_used_r >= byte_cnt_t'(BUFFER_BYTES)) begin
      bad = 1'b1;
    end else begin
      bytes_used_nxt = bytes_used_r + byte_cnt_t'(1);
      unique case (phase_r)
        PH_CMD: begin
          if (in_data_byte != 8'd0) bad = 1'b1;
          else phase_nxt = PH_UID;
        end
        PH_UID: begin
          uid_shift_nxt = uid_shifted;
          // bytes_used_r still lags by one, so the last uid byte sees four
          if (bytes_used_r == byte_cnt_t'(UID_END_COUNT - 1)) begin
            if (uid_shifted != request_uid_r) bad = 1'b1;
            else phase_nxt = PH_ID;
          end
        end
        PH_ID: begin
          held_id_nxt = in_data_byte;
          phase_nxt   = PH_LLO;
        end
        PH_LLO: begin
          remaining_len_nxt = {8'd0, in_data_byte};
          phase_nxt         = PH_LHI;
        end
        PH_LHI: begin
          remaining_len_nxt = len_full;
          if (held_id_r[7:2] != 6'd0 || (wanted & id_bit) == 4'd0 ||
              (seen_mask_r & id_bit) != 4'd0) begin
            bad = 1'b1;
          end else begin
            current_attr_nxt = held_id_r[1:0];
            fin_attr         = held_id_r[1:0];
            if (len_full > limit) bad = 1'b1;
            else if (len_full == 16'd0) fin = 1'b1;
            else phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          pv_nxt            = 1'b1;
          pa_nxt            = current_attr_r;
          pb_nxt            = in_data_byte;
          remaining_len_nxt = len_dec;
          if (len_dec == 16'd0) begin
            pl_nxt = 1'b1;
            fin    = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase
    end

    // attribute finished: mark it and check for completion
    fin_mask = seen_mask_r | (4'b0001 << fin_attr);
    if (fin && !bad) begin
      seen_mask_nxt = fin_mask;
      if (fin_mask == wanted) begin
        done_nxt   = 1'b1;
        status_nxt = ST_DONE;
      end else begin
        phase_nxt = PH_ID;
      end
    end

    if (bad) begin
      failed_nxt = 1'b1;
      status_nxt = ST_BAD;
      pv_nxt     = 1'b0;
      pa_nxt     = 2'd0;
      pb_nxt     = 8'd0;
      pl_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_uid_r   <= '0;
      expect_text_r   <= 1'b0;
      title_limit_r   <= 16'd64;
      message_limit_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REQUEST_UID:   request_uid_r   <= cfg_wdata;
        CFG_EXPECT_TEXT:   expect_text_r   <= cfg_wdata[0];
        CFG_TITLE_LIMIT:   title_limit_r   <= cfg_wdata[15:0];
        CFG_MESSAGE_LIMIT: message_limit_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_CMD;
      bytes_used_r    <= '0;
      uid_shift_r     <= '0;
      seen_mask_r     <= '0;
      current_attr_r  <= '0;
      remaining_len_r <= '0;
      done_r          <= 1'b0;
      failed_r        <= 1'b0;
      held_id_r       <= '0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      bytes_used_r    <= bytes_used_nxt;
      uid_shift_r     <= uid_shift_nxt;
      seen_mask_r     <= seen_mask_nxt;
      current_attr_r  <= current_attr_nxt;
      remaining_len_r <= remaining_len_nxt;
      done_r          <= done_nxt;
      failed_r        <= failed_nxt;
      held_id_r       <= held_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result beat payload, loaded only when a new beat is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pv_r     <= pv_nxt;
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      pl_r     <= pl_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_payload_valid = pv_r;
  assign out_payload_attr  = pa_r;
  assign out_payload_byte  = pb_r;
  assign out_payload_last  = pl_r;

endmodule

// ===== dv/notification_attribute_response_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notification_attribute_response_parser_tb
// Self-checking bench for the byte-wise response parser. A software copy of
// the parse state predicts status and payload tagging for every accepted
// byte. The stimulus is a set of directed responses followed by random
// well-formed, corrupted and noise responses under random register settings.
// Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module notification_attribute_response_parser_tb;
  import nap_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 250;
  localparam int QUIET_BEATS    = 50;

  typedef struct packed {
    status_t     status;
    logic        pvalid;
    logic [1:0]  attr;
    logic [7:0]  data;
    logic        last;
  } parse_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_index = CFG_REQUEST_UID;
  logic [31:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command = CMD_FEED;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic       out_payload_valid;
  logic [1:0] out_payload_attr;
  logic [7:0] out_payload_byte;
  logic       out_payload_last;

  notification_attribute_response_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_payload_valid(out_payload_valid),
    .out_payload_attr (out_payload_attr),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadows
  logic [31:0] reg_uid   = '0;
  logic        reg_text  = 1'b0;
  logic [15:0] reg_tlim  = 16'd64;
  logic [15:0] reg_mlim  = 16'd256;

  // predicted parse state
  phase_t      ps_phase  = PH_CMD;
  byte_cnt_t   ps_count  = '0;
  logic [31:0] ps_uid    = '0;
  logic [3:0]  ps_seen   = '0;
  logic [1:0]  ps_attr   = '0;
  logic [15:0] ps_left   = '0;
  logic        ps_done   = 1'b0;
  logic        ps_failed = 1'b0;
  logic [7:0]  ps_id     = '0;

  parse_result_t results_due [$];
  int  mismatches = 0;
  int  beats_sent = 0;
  bit  idle_on = 1'b1;
  int  stall_cnt = 0;
  int  quiet_cycles = 0;

  function automatic void clear_parse();
    ps_phase  = PH_CMD;
    ps_count  = '0;
    ps_uid    = '0;
    ps_seen   = '0;
    ps_attr   = '0;
    ps_left   = '0;
    ps_done   = 1'b0;
    ps_failed = 1'b0;
    ps_id     = '0;
  endfunction

  function automatic status_t close_attr(logic [3:0] want);
    ps_seen = ps_seen | (4'b0001 << ps_attr);
    if (ps_seen == want) begin
      ps_done = 1'b1;
      return ST_DONE;
    end
    ps_phase = PH_ID;
    return ST_MORE;
  endfunction

  function automatic parse_result_t parse_byte(logic cmd, logic [7:0] b);
    parse_result_t r;
    logic          bad;
    logic [3:0]    want;
    logic [15:0]   limit;
    r    = '0;
    r.status = ST_MORE;
    bad  = 1'b0;
    want = reg_text ? WANT_TEXT : WANT_APP;
    if (cmd == CMD_RESTART) begin
      clear_parse();
    end else if (ps_failed || ps_done || ps_count >= BUFFER_BYTES) begin
      bad = 1'b1;
    end else begin
      ps_count = ps_count + 1'b1;
      case (ps_phase)
        PH_CMD: begin
          if (b != 8'h00) bad = 1'b1;
          else ps_phase = PH_UID;
        end
        PH_UID: begin
          ps_uid = {b, ps_uid[31:8]};
          if (ps_count == UID_END_COUNT) begin
            if (ps_uid != reg_uid) bad = 1'b1;
            else ps_phase = PH_ID;
          end
        end
        PH_ID: begin
          ps_id    = b;
          ps_phase = PH_LLO;
        end
        PH_LLO: begin
          ps_left  = {8'h00, b};
          ps_phase = PH_LHI;
        end
        PH_LHI: begin
          // whole record header is in: id, repeat and length checks happen here
          ps_left[15:8] = b;
          if (ps_id > 8'd3 || !want[ps_id[1:0]] || ps_seen[ps_id[1:0]]) begin
            bad = 1'b1;
          end else begin
            ps_attr = ps_id[1:0];
            limit = (ps_attr == ATTR_APP) ? APP_LIMIT :
                    (ps_attr == ATTR_MESSAGE) ? reg_mlim : reg_tlim;
            if (ps_left > limit) bad = 1'b1;
            else if (ps_left == 16'd0) r.status = close_attr(want);
            else ps_phase = PH_PAY;
          end
        end
        default: begin
          r.pvalid = 1'b1;
          r.attr   = ps_attr;
          r.data   = b;
          ps_left  = ps_left - 1'b1;
          if (ps_left == 16'd0) begin
            r.last   = 1'b1;
            r.status = close_attr(want);
          end
        end
      endcase
    end
    if (bad) begin
      ps_failed = 1'b1;
      r = '0;
      r.status = ST_BAD;
    end
    return r;
  endfunction

  // one beat on the input channel; valid stays up unless a gap follows
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    results_due.push_back(parse_byte(cmd, b));
    beats_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] uid, input logic text,
                          input logic [15:0] tlim, input logic [15:0] mlim);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REQUEST_UID;
    cfg_wdata <= uid;
    @(posedge clk);
    cfg_index <= CFG_EXPECT_TEXT;
    cfg_wdata <= {31'd0, text};
    @(posedge clk);
    cfg_index <= CFG_TITLE_LIMIT;
    cfg_wdata <= {16'd0, tlim};
    @(posedge clk);
    cfg_index <= CFG_MESSAGE_LIMIT;
    cfg_wdata <= {16'd0, mlim};
    @(posedge clk);
    cfg_we   <= 1'b0;
    reg_uid  = uid;
    reg_text = text;
    reg_tlim = tlim;
    reg_mlim = mlim;
  endtask

  task automatic feed_header(input logic [7:0] lead, input logic [31:0] uid);
    send_beat(CMD_RESTART, 8'($urandom_range(0, 255)));
    send_beat(CMD_FEED, lead);
    for (int i = 0; i < 4; i++) send_beat(CMD_FEED, uid[8*i +: 8]);
  endtask

  task automatic feed_record(input logic [7:0] id, input logic [15:0] len);
    send_beat(CMD_FEED, id);
    send_beat(CMD_FEED, len[7:0]);
    send_beat(CMD_FEED, len[15:8]);
    for (int i = 0; i < len && !ps_failed && !ps_done; i++)
      send_beat(CMD_FEED, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hffff;
      default: return 16'($urandom_range(0, 16));
    endcase
  endfunction

  // mostly a legal length with short payload, now and then one over the limit
  function automatic logic [15:0] record_len(logic [7:0] id);
    int unsigned lim;
    lim = (id == 8'd0) ? 255 : (id == 8'd3) ? reg_mlim :
          (id == 8'd1 || id == 8'd2) ? reg_tlim : 16;
    if (lim < 65535 && $urandom_range(0, 11) == 0)
      return 16'($urandom_range(lim + 1, 65535));
    return 16'($urandom_range(0, lim > 12 ? 12 : lim));
  endfunction

  task automatic test_app_response();
    feed_header(8'h00, 32'h0);
    feed_record(8'd0, 16'd2);
    send_beat(CMD_FEED, 8'hff);   // past completion
    send_beat(CMD_FEED, 8'h00);   // still failed
    send_beat(CMD_RESTART, 8'hff);
  endtask

  task automatic test_header_errors();
    set_regs(32'hffff_ffff, 1'b0, 16'd64, 16'd256);
    feed_header(8'h80, 32'hffff_ffff);
    feed_header(8'h00, 32'h7fff_ffff);
  endtask

  task automatic test_text_records();
    set_regs(32'h0, 1'b1, 16'd0, 16'hffff);
    feed_header(8'h00, 32'h0);
    feed_record(8'd1, 16'd0);     // zero-length title
    feed_record(8'd3, 16'd1);
    feed_record(8'd1, 16'd0);     // repeated id
  endtask

  task automatic test_live_registers();
    set_regs(32'h1234_5678, 1'b0, 16'd64, 16'd256);
    feed_header(8'h00, 32'h1234_5678);
    // switch to text mode with the header already through
    set_regs(32'h1234_5678, 1'b1, 16'hffff, 16'd0);
    feed_record(8'd3, 16'd0);
    send_beat(CMD_FEED, 8'd1);
    send_beat(CMD_FEED, 8'd3);
    // title limit drops under the length before its high byte arrives
    set_regs(32'h1234_5678, 1'b1, 16'd2, 16'd0);
    send_beat(CMD_FEED, 8'd0);
  endtask

  task automatic test_buffer_overflow();
    logic [31:0] uid;
    uid = $urandom;
    set_regs(uid, 1'b1, 16'hffff, 16'hffff);
    feed_header(8'h00, uid);
    feed_record(8'd1, 16'd2000);  // runs into the buffer limit
    send_beat(CMD_RESTART, 8'h00);
  endtask

  task automatic random_response();
    logic [7:0]  ids [$];
    logic [7:0]  lead;
    logic [7:0]  tmp;
    logic [31:0] uid;
    int          j;
    if ($urandom_range(0, 3) == 0)
      set_regs($urandom, 1'($urandom_range(0, 1)), pick_limit(), pick_limit());
    if ($urandom_range(0, 9) == 0) begin
      send_beat(CMD_RESTART, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(3, 10))
        send_beat(($urandom_range(0, 9) == 0) ? CMD_RESTART : CMD_FEED,
                  8'($urandom_range(0, 255)));
      return;
    end
    lead = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    uid  = reg_uid;
    if ($urandom_range(0, 24) == 0) uid[$urandom_range(0, 31)] ^= 1'b1;
    feed_header(lead, uid);
    if (reg_text) begin
      ids = '{8'd1, 8'd2, 8'd3};
      for (int i = 2; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = ids[i];
        ids[i] = ids[j];
        ids[j] = tmp;
      end
    end else begin
      ids = '{8'd0};
    end
    foreach (ids[i]) begin
      if (ps_failed || ps_done || $urandom_range(0, 29) == 0) break;
      case ($urandom_range(0, 19))
        0:       ids[i] = 8'($urandom_range(0, 255));
        1:       ids[i] = 8'($urandom_range(0, 4));
        default: ;
      endcase
      feed_record(ids[i], record_len(ids[i]));
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_beat(CMD_FEED, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_responses();
    int first;
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      idle_on = (beats_sent - first < RANDOM_BEATS - QUIET_BEATS) &&
                ($urandom_range(0, 3) != 0);
      random_response();
    end
  endtask

  // sink side stall bursts
  always @(posedge clk) begin : sink_stall
    int nxt;
    if (stall_cnt > 0) nxt = stall_cnt - 1;
    else if (idle_on && $urandom_range(0, 7) == 0) nxt = $urandom_range(1, 9);
    else nxt = 0;
    stall_cnt <= nxt;
    out_stall <= (nxt != 0);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, status %0d",
                 $time, out_status);
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, out_status);
        check_field("payload_valid", want.pvalid, out_payload_valid);
        check_field("payload_attr", want.attr, out_payload_attr);
        check_field("payload_byte", want.data, out_payload_byte);
        check_field("payload_last", want.last, out_payload_last);
      end
    end
  end

  // cycles without a beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_app_response();
    test_header_errors();
    test_text_records();
    test_live_registers();
    test_buffer_overflow();
    test_random_responses();
    quiesce();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
